// ----- sv/dalt_pkg.sv -----
// Shared types and constants for the daily alarm table.
// Used by every module of the block and by its checker; no dependencies.
package dalt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int MS_PER_SEC          = 1000;
  localparam int PROD_W              = 26;   // 16-bit seconds times 1000
  localparam logic [5:0] WINDOW_RESET = 6'd5;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_EDIT   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] duration;
    logic        rec_valid;
    logic [4:0]  rec_day;
    logic [5:0]  rec_min;
  } entry_t;

  typedef struct packed {
    logic id_hit;
    logic due;
  } match_t;

endpackage

// ----- sv/dalt_mem.sv -----
// Alarm table storage: one write port, one read port, registered read data.
// Depends on dalt_pkg for the entry layout.
module dalt_mem #(
  parameter int TABLE_DEPTH = dalt_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  dalt_pkg::entry_t    wdata,
  input  logic [IDX_W-1:0]    raddr,
  output dalt_pkg::entry_t    rdata
);

  dalt_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dalt_match.sv -----
// Compares one stored alarm against the transaction being worked on.
// Depends on dalt_pkg for the entry layout and the match flags.
module dalt_match (
  input  dalt_pkg::entry_t entry,
  input  logic [15:0]      alarm_id,
  input  logic [4:0]       now_hour,
  input  logic [5:0]       now_minute,
  input  logic [5:0]       now_second,
  input  logic [4:0]       now_day,
  input  logic [5:0]       window,
  output dalt_pkg::match_t match
);

  logic fired_already;

  // an alarm that already fired on this day and minute is passed over
  assign fired_already = entry.rec_valid && (entry.rec_day == now_day)
                         && (entry.rec_min == now_minute);

  assign match.id_hit = (entry.id == alarm_id);
  assign match.due    = !fired_already && (entry.hour == now_hour)
                        && (entry.minute == now_minute) && (now_second < window);

endmodule

// ----- sv/daily_alarm_table_with_timed_output.sv -----
// Daily alarm table with timed output: top level and sequencer.
// One transaction at a time. A search reads the entries in order in S_SCAN and stops at
// the first hit; a miss goes to S_MISS (a tick then to S_TEND). A remove moves each later
// entry one place up in S_SHIFT; a firing tick forms its end time by a multiply, then an
// add in S_END_ADD. The next transaction is taken the cycle after the result loads.
// Reset clears count, output and window (to 5), not the table.
module daily_alarm_table_with_timed_output #(
  parameter int TABLE_DEPTH = dalt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] alarm_id,
  input  logic [4:0]  alarm_hour,
  input  logic [5:0]  alarm_minute,
  input  logic [15:0] duration_sec,
  input  logic [4:0]  now_hour,
  input  logic [5:0]  now_minute,
  input  logic [5:0]  now_second,
  input  logic [4:0]  now_day,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        output_on,
  output logic        fired,
  output logic [15:0] fired_id,
  output logic [4:0]  entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MISS, S_SHIFT, S_END_ADD, S_TEND, S_OUT
  } state_t;

  state_t state;

  // held copy of the transaction
  dalt_pkg::op_t op_q;
  logic [15:0]   id_q;
  logic [4:0]    hour_q;
  logic [5:0]    min_q;
  logic [15:0]   dur_q;
  logic [4:0]    nh_q;
  logic [5:0]    nm_q;
  logic [5:0]    ns_q;
  logic [4:0]    nd_q;
  logic [31:0]   nms_q;

  logic [5:0]                 trigger_window_sec;
  logic [CNT_W-1:0]           count;
  logic                       active;
  logic [31:0]                end_ms;
  logic [dalt_pkg::PROD_W-1:0] prod;
  logic [IDX_W-1:0]           idx;
  dalt_pkg::status_t          st_q;
  logic                       fired_q;
  logic [15:0]                fired_id_q;

  logic [CNT_W:0]   count_x;
  logic [CNT_W:0]   idx_p1;
  logic [CNT_W:0]   idx_p2;
  logic             hit;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  dalt_pkg::entry_t mem_wdata;
  logic [IDX_W-1:0] rd_addr;
  dalt_pkg::entry_t rdata;
  dalt_pkg::match_t match;

  assign count_x = (CNT_W+1)'(count);
  assign idx_p1  = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
  assign idx_p2  = (CNT_W+1)'(idx) + (CNT_W+1)'(2);
  assign hit     = (op_q == dalt_pkg::OP_TICK) ? match.due : match.id_hit;

  dalt_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  dalt_match u_match (
    .entry      (rdata),
    .alarm_id   (id_q),
    .now_hour   (nh_q),
    .now_minute (nm_q),
    .now_second (ns_q),
    .now_day    (nd_q),
    .window     (trigger_window_sec),
    .match      (match)
  );

  // table write and read address
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rdata;
    rd_addr   = idx;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
      end
      S_SCAN: begin
        if (hit) begin
          if (op_q == dalt_pkg::OP_EDIT) begin
            mem_we             = 1'b1;
            mem_wdata.hour     = hour_q;
            mem_wdata.minute   = min_q;
            mem_wdata.duration = dur_q;
          end else if (op_q == dalt_pkg::OP_TICK) begin
            mem_we              = 1'b1;
            mem_wdata.rec_valid = 1'b1;
            mem_wdata.rec_day   = nd_q;
            mem_wdata.rec_min   = nm_q;
          end
          rd_addr = IDX_W'(idx_p1);
        end else if (idx_p1 < count_x) begin
          rd_addr = IDX_W'(idx_p1);
        end
      end
      S_SHIFT: begin
        // move the entry below one place up
        mem_we  = 1'b1;
        rd_addr = IDX_W'(idx_p2);
      end
      S_MISS: begin
        if (op_q == dalt_pkg::OP_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(count);
          mem_wdata = '{id: id_q, hour: hour_q, minute: min_q, duration: dur_q,
                        rec_valid: 1'b0, rec_day: '0, rec_min: '0};
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      trigger_window_sec <= dalt_pkg::WINDOW_RESET;
      count              <= '0;
      active             <= 1'b0;
      end_ms             <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        trigger_window_sec <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= dalt_pkg::op_t'(operation);
            id_q       <= alarm_id;
            hour_q     <= alarm_hour;
            min_q      <= alarm_minute;
            dur_q      <= duration_sec;
            nh_q       <= now_hour;
            nm_q       <= now_minute;
            ns_q       <= now_second;
            nd_q       <= now_day;
            nms_q      <= now_ms;
            idx        <= '0;
            st_q       <= dalt_pkg::ST_OK;
            fired_q    <= 1'b0;
            fired_id_q <= '0;
            case (operation)
              dalt_pkg::OP_ADD: begin
                if (count_x >= DEPTH_X) begin
                  st_q  <= dalt_pkg::ST_FULL;
                  state <= S_OUT;
                end else begin
                  state <= (count == '0) ? S_MISS : S_SCAN;
                end
              end
              dalt_pkg::OP_EDIT, dalt_pkg::OP_REMOVE, dalt_pkg::OP_LOOKUP,
              dalt_pkg::OP_TICK: begin
                state <= (count == '0) ? S_MISS : S_SCAN;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            case (op_q)
              dalt_pkg::OP_ADD: begin
                st_q  <= dalt_pkg::ST_EXISTS;
                state <= S_OUT;
              end
              dalt_pkg::OP_REMOVE: begin
                if (idx_p1 < count_x) begin
                  state <= S_SHIFT;
                end else begin
                  count <= count - CNT_W'(1);
                  state <= S_OUT;
                end
              end
              dalt_pkg::OP_TICK: begin
                fired_q    <= 1'b1;
                fired_id_q <= rdata.id;
                prod       <= dalt_pkg::PROD_W'(rdata.duration)
                              * dalt_pkg::PROD_W'(dalt_pkg::MS_PER_SEC);
                state      <= S_END_ADD;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end else if (idx_p1 < count_x) begin
            idx <= IDX_W'(idx_p1);
          end else begin
            state <= S_MISS;
          end
        end
        S_SHIFT: begin
          if (idx_p2 < count_x) begin
            idx <= IDX_W'(idx_p1);
          end else begin
            count <= count - CNT_W'(1);
            state <= S_OUT;
          end
        end
        S_MISS: begin
          case (op_q)
            dalt_pkg::OP_ADD: begin
              count <= count + CNT_W'(1);
              state <= S_OUT;
            end
            dalt_pkg::OP_TICK: begin
              state <= S_TEND;
            end
            default: begin
              st_q  <= dalt_pkg::ST_NOTFOUND;
              state <= S_OUT;
            end
          endcase
        end
        S_END_ADD: begin
          end_ms <= nms_q + 32'(prod);
          active <= 1'b1;
          state  <= S_TEND;
        end
        S_TEND: begin
          // drop the output once the end time is reached
          if (active && (nms_q >= end_ms)) begin
            active <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= st_q;
            output_on   <= active;
            fired       <= fired_q;
            fired_id    <= fired_id_q;
            entry_count <= 5'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/dalt_chk.sv -----
// Port-level checker for the daily alarm table, bound to the top level.
// Depends on dalt_pkg for the status codes.
module dalt_chk #(
  parameter int TABLE_DEPTH = dalt_pkg::TABLE_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        output_on,
  input logic        fired,
  input logic [15:0] fired_id,
  input logic [4:0]  entry_count
);

  // a firing tick always reports success
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == dalt_pkg::ST_OK)
    else $error("fired transaction with non-ok status");

  a_no_fire_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> fired_id == 16'd0)
    else $error("fired_id set without a firing");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dalt_pkg::ST_FULL |-> entry_count == 5'(TABLE_DEPTH))
    else $error("table full reported below depth");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fired_id)
      && $stable(entry_count) && $stable(output_on))
    else $error("stalled result changed");

  // one transaction at a time: input closes right after a handshake
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a transaction was taken");

endmodule

bind daily_alarm_table_with_timed_output dalt_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_dalt_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .output_on   (output_on),
  .fired       (fired),
  .fired_id    (fired_id),
  .entry_count (entry_count)
);
